@@ rtl/u2u_pkg.sv @@
// ---------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the utf-8 to utf-16 decoder.
// ---------------------------------------------------------------------------
package u2u_pkg;

   // default depth of the queue between decoder front and emitter back
   localparam int U2U_QUEUE_DEPTH = 4;

   // job kinds handed from front to back
   localparam logic [1:0] JOB_SINGLE = 2'd0;
   localparam logic [1:0] JOB_PAIR   = 2'd1;
   localparam logic [1:0] JOB_ERROR  = 2'd2;

   // utf-16 surrogate bases and supplementary offset
   localparam logic [15:0] HIGH_SURROGATE = 16'hD800;
   localparam logic [15:0] LOW_SURROGATE  = 16'hDC00;
   localparam logic [20:0] SUPP_OFFSET    = 21'h010000;

   // input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } u2u_req_type;

   // result item
   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_error;
      logic        last_of_run;
      logic        end_of_string;
   } u2u_rsp_type;

   // decoded job: single unit value, offset value of a pair, or error
   typedef struct packed {
      logic [1:0]  kind;
      logic [19:0] payload;
      logic        last;
   } u2u_job_type;

   // front to queue write port
   typedef struct packed {
      logic        push;
      u2u_job_type job;
   } u2u_wr_type;

endpackage

@@ rtl/utf8_to_utf16_decoder.sv @@
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream to UTF-16 code unit stream.
// ---------------------------------------------------------------------------
// Input queue side: drive req_data (one byte plus a last-byte flag) and
// raise req_push; a transfer happens when req_full is low.
// Result queue side: while rsp_empty is low, rsp_data holds the oldest
// code unit with its flags; raise rsp_pop to take it.
// The front decodes one byte per cycle while req_full is low and writes a
// job into a job queue of QUEUE_DEPTH entries; the back expands jobs into
// results in an output register and gives one result per cycle while the
// receiver takes them. A code point at or above 0x10000 gives a surrogate
// pair, high unit first, and its job stays queued until both units are out.
// Malformed input gives one error result and the remaining bytes of the
// string are dropped.
// Reset clears the decode state, the job queue and the output valid flag.
// When the receiver stalls, the output register and job queue fill, and
// req_full then rises until results are taken.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder
   import u2u_pkg::*;
#(
   parameter int QUEUE_DEPTH = U2U_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  u2u_req_type req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output u2u_rsp_type rsp_data
);

   u2u_wr_type  wr;
   u2u_job_type head;
   logic        job_empty;
   logic        job_pop;
   logic        accept;

   assign accept = req_push && !req_full;

   // byte decoder
   u2u_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .wr     (wr)
   );

   // job queue
   u2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .full  (req_full),
      .empty (job_empty),
      .pop   (job_pop),
      .head  (head)
   );

   // result emitter
   u2u_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (head),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/u2u_front.sv @@
// ---------------------------------------------------------------------------
// u2u_front
// Byte decoder: tracks pending continuation bytes and the code accumulator,
// and turns each completed code point or error into one job.
// ---------------------------------------------------------------------------
module u2u_front
   import u2u_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  u2u_req_type req,
   output u2u_wr_type  wr
);

   logic [1:0]  pending_ff, pending_in;
   logic [20:0] acc_ff, acc_in;
   logic        skip_ff, skip_in;

   logic [7:0]  b;
   logic        last;
   logic [20:0] acc_next;
   logic [20:0] supp_value;

   assign b        = req.data_byte;
   assign last     = req.last_byte;
   assign acc_next = {acc_ff[14:0], b[5:0]};
   assign supp_value = acc_next - SUPP_OFFSET;

   // classify byte and update decode state
   always_comb begin
      pending_in  = pending_ff;
      acc_in      = acc_ff;
      skip_in     = skip_ff;
      wr.push     = 1'b0;
      wr.job.kind = JOB_SINGLE;
      wr.job.payload = '0;
      wr.job.last = last;
      if (accept) begin
         if (skip_ff) begin
            // drop bytes up to the end of the string
            if (last) begin
               skip_in = 1'b0;
            end
         end else if (pending_ff == 2'd0) begin
            if (b inside {[8'h00:8'h7F]}) begin
               wr.push        = 1'b1;
               wr.job.kind    = JOB_SINGLE;
               wr.job.payload = {12'd0, b};
            end else if (b inside {[8'hC0:8'hF7]} && !last) begin
               // lead byte opens a sequence
               if (b inside {[8'hC0:8'hDF]}) begin
                  pending_in = 2'd1;
                  acc_in     = {16'd0, b[4:0]};
               end else if (b inside {[8'hE0:8'hEF]}) begin
                  pending_in = 2'd2;
                  acc_in     = {17'd0, b[3:0]};
               end else begin
                  pending_in = 2'd3;
                  acc_in     = {18'd0, b[2:0]};
               end
            end else begin
               // bad lead, or lead flagged as last byte
               wr.push     = 1'b1;
               wr.job.kind = JOB_ERROR;
               pending_in  = 2'd0;
               acc_in      = '0;
               skip_in     = !last;
            end
         end else if (b[7:6] != 2'b10) begin
            // missing continuation
            wr.push     = 1'b1;
            wr.job.kind = JOB_ERROR;
            pending_in  = 2'd0;
            acc_in      = '0;
            skip_in     = !last;
         end else if (pending_ff == 2'd1) begin
            // code point complete
            pending_in = 2'd0;
            acc_in     = '0;
            wr.push    = 1'b1;
            if (acc_next[20:16] != 5'd0) begin
               wr.job.kind    = JOB_PAIR;
               wr.job.payload = supp_value[19:0];
            end else begin
               wr.job.kind    = JOB_SINGLE;
               wr.job.payload = {4'd0, acc_next[15:0]};
            end
         end else if (last) begin
            // string ends mid-sequence
            wr.push     = 1'b1;
            wr.job.kind = JOB_ERROR;
            pending_in  = 2'd0;
            acc_in      = '0;
            skip_in     = 1'b0;
         end else begin
            pending_in = pending_ff - 2'd1;
            acc_in     = acc_next;
         end
      end
   end

   // decode state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         acc_ff     <= '0;
         skip_ff    <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
         skip_ff    <= skip_in;
      end
   end

endmodule

@@ rtl/u2u_queue.sv @@
// ---------------------------------------------------------------------------
// u2u_queue
// Small register queue of decoded jobs between front and back.
// ---------------------------------------------------------------------------
module u2u_queue
   import u2u_pkg::*;
#(
   parameter int DEPTH = U2U_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  u2u_wr_type  wr,
   output logic        full,
   output logic        empty,
   input  logic        pop,
   output u2u_job_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u2u_job_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]        wptr_ff, wptr_in;
   logic [PTR_W-1:0]        rptr_ff, rptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_pop;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = mem_ff[rptr_ff];
   assign do_pop = pop && !empty;

   // pointer and count update
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (wr.push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (wr.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !wr.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (wr.push) begin
         mem_ff[wptr_ff] <= wr.job;
      end
   end

endmodule

@@ rtl/u2u_back.sv @@
// ---------------------------------------------------------------------------
// u2u_back
// Result emitter: expands each job into one or two utf-16 results and holds
// them in an output register.
// ---------------------------------------------------------------------------
module u2u_back
   import u2u_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_empty,
   input  u2u_job_type job,
   output logic        job_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output u2u_rsp_type rsp_data
);

   logic        out_valid_ff, out_valid_in;
   u2u_rsp_type out_ff, out_in;
   logic        second_ff, second_in;
   logic        load;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign load      = (!out_valid_ff || rsp_pop) && !job_empty;

   // build next result from head job
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      second_in    = second_ff;
      job_pop      = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         case (job.kind)
            JOB_PAIR: begin
               if (!second_ff) begin
                  out_in.code_unit     = HIGH_SURROGATE | {6'd0, job.payload[19:10]};
                  out_in.is_error      = 1'b0;
                  out_in.last_of_run   = 1'b0;
                  out_in.end_of_string = 1'b0;
                  second_in            = 1'b1;
               end else begin
                  out_in.code_unit     = LOW_SURROGATE | {6'd0, job.payload[9:0]};
                  out_in.is_error      = 1'b0;
                  out_in.last_of_run   = 1'b1;
                  out_in.end_of_string = job.last;
                  second_in            = 1'b0;
                  job_pop              = 1'b1;
               end
            end
            JOB_ERROR: begin
               out_in.code_unit     = '0;
               out_in.is_error      = 1'b1;
               out_in.last_of_run   = 1'b1;
               out_in.end_of_string = 1'b1;
               job_pop              = 1'b1;
            end
            default: begin
               out_in.code_unit     = job.payload[15:0];
               out_in.is_error      = 1'b0;
               out_in.last_of_run   = 1'b1;
               out_in.end_of_string = job.last;
               job_pop              = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

@@ rtl/u2u_checker.sv @@
// ---------------------------------------------------------------------------
// u2u_checker
// Port-level checks on the decoder, bound to the top level.
// ---------------------------------------------------------------------------
module u2u_checker
   import u2u_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input u2u_rsp_type rsp_data
);

   // nothing waits on the result side after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // the input side is open right after reset
   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // an error result is a zero unit that closes the run and the string
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.is_error) |->
         (rsp_data.code_unit == 16'd0 && rsp_data.last_of_run &&
          rsp_data.end_of_string))
      else $error("malformed error result");

   // a stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("result withdrawn while stalled");

   // a stalled result keeps its value
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind utf8_to_utf16_decoder u2u_checker u_checker (.*);
